// ===== hw/rtl/dependency_checked_issue_queue_macros.svh =====
// Assertion macros for the dependency checked issue queue.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DEPENDENCY_CHECKED_ISSUE_QUEUE_MACROS_SVH
`define DEPENDENCY_CHECKED_ISSUE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DCQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcq assertion failed");

// Next-cycle implication, disabled during reset
`define DCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcq assertion failed");

`endif

// ===== hw/rtl/dcq_pkg.sv =====
// Shared types and constants for the dependency checked issue queue.
// No dependencies; used by dcq_dep_check and dependency_checked_issue_queue.
package dcq_pkg;

   localparam int ID_PORT_W   = 8;
   localparam int TAG_W       = 16;
   localparam int LIMIT_W     = 5;
   localparam int DATA_W      = 3 * ID_PORT_W + TAG_W;
   localparam int EPOCH_W     = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SCAN   = 1'b1;

   typedef enum logic [1:0] {
      KIND_INS_OK   = 2'd0,
      KIND_INS_FULL = 2'd1,
      KIND_ISSUE    = 2'd2,
      KIND_EMPTY    = 2'd3
   } dcq_kind_type;

   // Requests from the scan pipeline to the dependency checker
   typedef struct packed {
      logic look_en;
      logic mark_en;
      logic scan_done;
   } dcq_chk_ctl_type;

   // Status back from the dependency checker
   typedef struct packed {
      logic clearing;
      logic blocked;
   } dcq_chk_sts_type;

endpackage

// ===== hw/rtl/dcq_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module dcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write, then register both reads (old data on a same-address collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== hw/rtl/dcq_dep_check.sv =====
// Destination set of the running scan: an epoch-marked RAM indexed by id.
// Depends on dcq_pkg, dcq_ram and the assertion macro header.
`include "dependency_checked_issue_queue_macros.svh"

module dcq_dep_check #(
   parameter int ID_WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dcq_pkg::dcq_chk_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]      look_a,
   input  logic [ID_WIDTH-1:0]      look_b,
   input  logic [ID_WIDTH-1:0]      mark_id,
   output dcq_pkg::dcq_chk_sts_type sts
);

   localparam int MARK_DEPTH = 1 << ID_WIDTH;
   localparam int EPOCH_W    = dcq_pkg::EPOCH_W;

   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic                clr_ff, clr_in;
   logic [ID_WIDTH-1:0] clr_addr_ff, clr_addr_in;
   logic [ID_WIDTH-1:0] look_a_ff, look_b_ff;
   logic                fwd_vld_ff;
   logic [ID_WIDTH-1:0] fwd_id_ff;

   logic                wr_en;
   logic [ID_WIDTH-1:0] wr_addr;
   logic [EPOCH_W-1:0]  wr_data;
   logic [EPOCH_W-1:0]  rd_a_data, rd_b_data;
   logic                hit_a, hit_b;

   // Sweep zeros during a clear pass, else stamp the current epoch on a mark
   assign wr_en   = clr_ff | ctl.mark_en;
   assign wr_addr = clr_ff ? clr_addr_ff : mark_id;
   assign wr_data = clr_ff ? '0 : epoch_ff;

   dcq_ram #(
      .WIDTH (EPOCH_W),
      .DEPTH (MARK_DEPTH)
   ) u_mark_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (look_a),
      .rd_a_data (rd_a_data),
      .rd_b_addr (look_b),
      .rd_b_data (rd_b_data)
   );

   // Advance the epoch per scan; on wrap, start a clear pass
   always_comb begin
      epoch_in    = epoch_ff;
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_in = 1'b0;
         end
      end
      if (ctl.scan_done) begin
         if (epoch_ff == '1) begin
            epoch_in    = EPOCH_W'(1);
            clr_in      = 1'b1;
            clr_addr_in = '0;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff    <= EPOCH_W'(1);
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         fwd_vld_ff  <= 1'b0;
      end else begin
         epoch_ff    <= epoch_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         fwd_vld_ff  <= ctl.look_en & ctl.mark_en;
      end
      look_a_ff <= look_a;
      look_b_ff <= look_b;
      fwd_id_ff <= mark_id;
   end

   // Forward a mark written in the same cycle as the lookup read
   assign hit_a = (rd_a_data == epoch_ff) || (fwd_vld_ff && (fwd_id_ff == look_a_ff));
   assign hit_b = (rd_b_data == epoch_ff) || (fwd_vld_ff && (fwd_id_ff == look_b_ff));

   assign sts.clearing = clr_ff;
   assign sts.blocked  = hit_a | hit_b;

   `DCQ_ASSERT_IMPLY(a_no_mark_in_clear, clock, reset, clr_ff, !ctl.mark_en && !ctl.look_en)
   `DCQ_ASSERT_IMPLY(a_epoch_nonzero, clock, reset, 1'b1, epoch_ff != '0)
   `DCQ_ASSERT_NEXT(a_wrap_clears, clock, reset, ctl.scan_done && (epoch_ff == '1), clr_ff)

endmodule

// ===== hw/rtl/dependency_checked_issue_queue.sv =====
// Dependency checked issue queue: in-order pending table with dependency scan.
// Block use:
//   req channel: tuser = operation (insert or scan), tdata = {tag, dest, src_b, src_a}.
//   rsp channel: tuser = result kind, tlast = final result of one request,
//   tdata = {tag, dest, src_b, src_a} of an issued entry, zero otherwise.
//   csr channel: writes the 5-bit table limit; always ready. The user must
//   write it only while idle; the block does not enforce this. An insert gives
//   one result in the cycle after its transfer; a scan of an empty table gives
//   one empty result the same way. A scan of N entries streams the entry RAM
//   one entry per cycle through a read, lookup and decide pipeline, unless a
//   stalled rsp channel holds an issue. Each issued result leaves when the next
//   issue is found or the scan ends, since only then is tlast known.
//   The next request is taken once the previous one is complete.
//   Reset empties the table, sets the limit to 16 and starts a clear pass of
//   all 2^ID_WIDTH entries of the destination mark RAM; the pass repeats after
//   every 255 scans of a non-empty table. No request is taken during a clear pass.
//   A stalled rsp channel holds the result and halts the scan only at an issue.
// Depends on dcq_pkg, dcq_ram, dcq_dep_check and the assertion macro header.
`include "dependency_checked_issue_queue_macros.svh"

module dependency_checked_issue_queue #(
   parameter int TABLE_DEPTH = 16,
   parameter int ID_WIDTH    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // req: tdata = src_a_id[7:0], src_b_id[15:8], dest_id[23:16], instr_tag[39:24]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dcq_pkg::DATA_W-1:0]      req_tdata,
   input  logic                            req_tuser,  // operation
   // rsp: tdata = out_src_a_id[7:0], out_src_b_id[15:8], out_dest_id[23:16],
   //      out_tag[39:24]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dcq_pkg::DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                      rsp_tuser,  // kind
   output logic                            rsp_tlast,  // last
   // csr: table_limit
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dcq_pkg::LIMIT_W-1:0]     csr_data
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int TAG_W  = dcq_pkg::TAG_W;
   localparam int PID_W  = dcq_pkg::ID_PORT_W;
   localparam int ENT_W  = 3 * ID_WIDTH + TAG_W;
   localparam int CMP_W  = (CNT_W > dcq_pkg::LIMIT_W) ? CNT_W : dcq_pkg::LIMIT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [dcq_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           keep_ff, keep_in;
   logic                       b_vld_ff, b_vld_in;
   logic                       c_vld_ff, c_vld_in;
   logic                       c_new_ff, c_new_in;
   logic                       c_blk_ff, c_blk_in;
   logic [ENT_W-1:0]           c_ent_ff, c_ent_in;
   logic                       pend_vld_ff, pend_vld_in;
   logic [ENT_W-1:0]           pend_ent_ff, pend_ent_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   dcq_pkg::dcq_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [dcq_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free, req_go, full;
   logic                       c_blocked, c_issue, c_go, b_adv;
   logic [CNT_W-1:0]           idx_nxt;
   logic [CMP_W-1:0]           cnt_ext, lim_ext, eff_lim;
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0]           ram_wr_data, ram_rd_data;
   dcq_pkg::dcq_chk_ctl_type   chk_ctl;
   dcq_pkg::dcq_chk_sts_type   chk_sts;

   // Port id to stored id width
   function automatic logic [ID_WIDTH-1:0] id_in(input logic [PID_W-1:0] v);
      logic [ID_WIDTH+PID_W-1:0] w;
      w = {{ID_WIDTH{1'b0}}, v};
      return w[ID_WIDTH-1:0];
   endfunction

   // Stored id to port width
   function automatic logic [PID_W-1:0] id_out(input logic [ID_WIDTH-1:0] v);
      logic [ID_WIDTH+PID_W-1:0] w;
      w = {{PID_W{1'b0}}, v};
      return w[PID_W-1:0];
   endfunction

   // Stored entry {tag, dest, src_b, src_a} to result payload
   function automatic logic [dcq_pkg::DATA_W-1:0] ent_out(input logic [ENT_W-1:0] e);
      return {e[ENT_W-1:3*ID_WIDTH],
              id_out(e[3*ID_WIDTH-1:2*ID_WIDTH]),
              id_out(e[2*ID_WIDTH-1:ID_WIDTH]),
              id_out(e[ID_WIDTH-1:0])};
   endfunction

   // Effective limit is the register capped at the table depth
   assign cnt_ext = CMP_W'(count_ff);
   assign lim_ext = CMP_W'(limit_ff);
   assign eff_lim = (lim_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : lim_ext;
   assign full    = cnt_ext >= eff_lim;

   // Handshake and scan pipeline control
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !chk_sts.clearing && out_free;
   assign req_go     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign c_blocked   = c_new_ff ? chk_sts.blocked : c_blk_ff;
   assign c_issue     = c_vld_ff && !c_blocked;
   assign c_go        = c_vld_ff && !(c_issue && pend_vld_ff && !out_free);
   assign b_adv       = b_vld_ff && (!c_vld_ff || c_go);
   assign idx_nxt     = idx_ff + 1'b1;
   assign ram_rd_addr = b_adv ? idx_nxt[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];

   // Write port: append on insert, close up kept entries during a scan
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = keep_ff[ADDR_W-1:0];
      ram_wr_data = c_ent_ff;
      if (req_go && (req_tuser == dcq_pkg::OP_INSERT) && !full) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = count_ff[ADDR_W-1:0];
         ram_wr_data = {req_tdata[dcq_pkg::DATA_W-1:3*PID_W],
                        id_in(req_tdata[3*PID_W-1:2*PID_W]),
                        id_in(req_tdata[2*PID_W-1:PID_W]),
                        id_in(req_tdata[PID_W-1:0])};
      end else if (c_go && !c_issue) begin
         ram_wr_en = 1'b1;
      end
   end

   dcq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_a_addr (ram_rd_addr),
      .rd_a_data (ram_rd_data),
      .rd_b_addr (ram_rd_addr),
      .rd_b_data ()
   );

   // Look up sources as an entry moves into decide; mark its dest as it leaves
   assign chk_ctl.look_en   = b_adv;
   assign chk_ctl.mark_en   = c_go;
   assign chk_ctl.scan_done = (state_ff == ST_DONE) && out_free;

   dcq_dep_check #(
      .ID_WIDTH (ID_WIDTH)
   ) u_dep_check (
      .clock   (clock),
      .reset   (reset),
      .ctl     (chk_ctl),
      .look_a  (ram_rd_data[ID_WIDTH-1:0]),
      .look_b  (ram_rd_data[2*ID_WIDTH-1:ID_WIDTH]),
      .mark_id (c_ent_ff[3*ID_WIDTH-1:2*ID_WIDTH]),
      .sts     (chk_sts)
   );

   // Next state
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      limit_in    = csr_valid ? csr_data : limit_ff;
      total_in    = total_ff;
      idx_in      = idx_ff;
      keep_in     = keep_ff;
      b_vld_in    = b_vld_ff;
      c_vld_in    = c_vld_ff;
      c_new_in    = 1'b0;
      c_blk_in    = c_blocked;
      c_ent_in    = c_ent_ff;
      pend_vld_in = pend_vld_ff;
      pend_ent_in = pend_ent_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               rsp_data_in = '0;
               if (req_tuser == dcq_pkg::OP_INSERT) begin
                  rsp_kind_in = full ? dcq_pkg::KIND_INS_FULL : dcq_pkg::KIND_INS_OK;
                  if (!full) begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_kind_in = dcq_pkg::KIND_EMPTY;
               end else begin
                  rsp_vld_in  = rsp_vld_ff && !rsp_tready;
                  rsp_kind_in = rsp_kind_ff;
                  rsp_data_in = rsp_data_ff;
                  rsp_last_in = rsp_last_ff;
                  state_in    = ST_SCAN;
                  total_in    = count_ff;
                  idx_in      = '0;
                  keep_in     = '0;
                  b_vld_in    = 1'b1;
                  c_vld_in    = 1'b0;
                  pend_vld_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // Move the read entry into decide when decide frees up
            if (!c_vld_ff || c_go) begin
               c_vld_in = b_vld_ff;
               c_new_in = b_vld_ff;
               c_ent_in = ram_rd_data;
            end
            if (b_adv) begin
               idx_in   = idx_nxt;
               b_vld_in = idx_nxt < total_ff;
            end
            // Issue into the pending slot, pushing out the one held there
            if (c_go) begin
               if (c_issue) begin
                  pend_vld_in = 1'b1;
                  pend_ent_in = c_ent_ff;
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = dcq_pkg::KIND_ISSUE;
                     rsp_data_in = ent_out(pend_ent_ff);
                     rsp_last_in = 1'b0;
                  end
               end else begin
                  keep_in = keep_ff + 1'b1;
               end
            end
            if (!b_vld_ff && !c_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Release the final issue with tlast and commit the new count
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = dcq_pkg::KIND_ISSUE;
               rsp_data_in = ent_out(pend_ent_ff);
               rsp_last_in = 1'b1;
               pend_vld_in = 1'b0;
               count_in    = keep_ff;
               idx_in      = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         limit_ff    <= dcq_pkg::LIMIT_RESET;
         idx_ff      <= '0;
         keep_ff     <= '0;
         b_vld_ff    <= 1'b0;
         c_vld_ff    <= 1'b0;
         c_new_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         limit_ff    <= limit_in;
         idx_ff      <= idx_in;
         keep_ff     <= keep_in;
         b_vld_ff    <= b_vld_in;
         c_vld_ff    <= c_vld_in;
         c_new_ff    <= c_new_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      total_ff    <= total_in;
      c_blk_ff    <= c_blk_in;
      c_ent_ff    <= c_ent_in;
      pend_ent_ff <= pend_ent_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `DCQ_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `DCQ_ASSERT_IMPLY(a_keep_behind_read, clock, reset, state_ff == ST_SCAN, keep_ff <= idx_ff)
   `DCQ_ASSERT_IMPLY(a_done_has_issue, clock, reset, state_ff == ST_DONE, pend_vld_ff)
   `DCQ_ASSERT_IMPLY(a_stall_only_issue, clock, reset, c_vld_ff && !c_go,
                     c_issue && pend_vld_ff && rsp_vld_ff)
   `DCQ_ASSERT_IMPLY(a_no_req_busy, clock, reset, state_ff != ST_IDLE, !req_tready)

endmodule
